[hdl/srrc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the source route repeat check.
// Depends on nothing; used by srrc_store, source_route_repeat_check and tb_top.
package srrc_pkg;

    localparam int MAX_ADDRS = 16;
    localparam int CNT_W     = $clog2(MAX_ADDRS + 1);
    localparam int IDX_W     = $clog2(MAX_ADDRS);
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 2;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [IDX_W-1:0]    t_index;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_CLEAN    = 2'd0;
    localparam t_status ST_REPEAT   = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    localparam t_count COUNT_FULL = CNT_W'(MAX_ADDRS);

endpackage

[hdl/srrc_store.sv]
`timescale 1ns / 1ps
// Address store for one route with a parallel compare against all valid entries.
// Depends on srrc_pkg.
module srrc_store (
    input  logic            i_clk,
    input  logic            i_we,
    input  srrc_pkg::t_index i_waddr,
    input  srrc_pkg::t_addr i_wdata,
    input  srrc_pkg::t_addr i_addr,
    input  srrc_pkg::t_count i_count,
    output logic            o_hit
);

    srrc_pkg::t_addr r_mem [srrc_pkg::MAX_ADDRS];
    logic [srrc_pkg::MAX_ADDRS-1:0] match;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // compare only entries below the fill count
    always_comb begin
        for (int i = 0; i < srrc_pkg::MAX_ADDRS; i++) begin
            match[i] = (srrc_pkg::CNT_W'(i) < i_count) && (r_mem[i] == i_addr);
        end
    end

    assign o_hit = |match;

endmodule

[hdl/source_route_repeat_check.sv]
`timescale 1ns / 1ps
// Top level of the source route repeat check.
// Depends on srrc_pkg and srrc_store.
//
// Usage:
//   Input channel (i_valid, o_stall, i_addr, i_is_last) carries one route
//   address per beat: the source, then each hop, then the destination with
//   i_is_last set. A beat is taken when i_valid is high and o_stall is low.
//   Output channel (o_valid, i_stall, o_status) carries one status beat per
//   route, on its last address: clean, repeat, or overflow when the route
//   held more than MAX_ADDRS non-last addresses. Overflow wins over repeat.
//   A status beat goes through the input register, then the result register,
//   to o_valid. Throughput: one address per cycle while o_stall is low, set
//   by the parallel compare of the registered address to all stored entries.
//   When the receiver stalls, the status beat holds in the result register;
//   non-last addresses keep flowing, and a last address waits in the input
//   register until the result register frees, which raises o_stall.
//   Reset empties the route (count and marks cleared) and drops all beats;
//   store contents are not cleared, since only counted entries are compared.
module source_route_repeat_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  srrc_pkg::t_addr       i_addr,
    input  logic                  i_is_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output srrc_pkg::t_status     o_status
);

    logic              r_in_valid;
    srrc_pkg::t_addr   r_addr;
    logic              r_last;
    srrc_pkg::t_count  r_count;
    logic              r_repeat;
    logic              r_overflow;
    logic              r_out_valid;
    srrc_pkg::t_status r_status;

    logic              n_in_valid;
    srrc_pkg::t_count  n_count;
    logic              n_repeat;
    logic              n_overflow;
    logic              n_out_valid;
    srrc_pkg::t_status n_status;

    logic hit;
    logic out_free;
    logic fire;
    logic full;
    logic we;
    logic in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && (!r_last || out_free);
    assign o_stall  = r_in_valid && !fire;
    assign in_take  = i_valid && !o_stall;
    assign full     = (r_count == srrc_pkg::COUNT_FULL);
    assign we       = fire && !r_last && !full;

    srrc_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[srrc_pkg::IDX_W-1:0]),
        .i_wdata (r_addr),
        .i_addr  (r_addr),
        .i_count (r_count),
        .o_hit   (hit)
    );

    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (r_in_valid && !fire);
        n_count     = r_count;
        n_repeat    = r_repeat;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        if (fire) begin
            if (r_last) begin
                n_out_valid = 1'b1;
                if (r_overflow) begin
                    n_status = srrc_pkg::ST_OVERFLOW;
                end else if (r_repeat || hit) begin
                    n_status = srrc_pkg::ST_REPEAT;
                end else begin
                    n_status = srrc_pkg::ST_CLEAN;
                end
                n_count    = '0;
                n_repeat   = 1'b0;
                n_overflow = 1'b0;
            end else begin
                n_repeat = r_repeat || hit;
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = r_count + srrc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_repeat    <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_count     <= n_count;
            r_repeat    <= n_repeat;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr <= i_addr;
            r_last <= i_is_last;
        end
        r_status <= n_status;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for source_route_repeat_check: feeds directed and random routes,
// predicts each route status and checks every status beat in order.
// Depends on srrc_pkg and the source_route_repeat_check RTL.
module tb_top;

    localparam int          CALM_TAIL   = 150;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        srrc_pkg::t_addr addr;
        logic            last;
    } t_route_beat;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    srrc_pkg::t_addr   i_addr    = '0;
    logic              i_is_last = 1'b0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    srrc_pkg::t_status o_status;

    t_route_beat       pending_beats[$];
    srrc_pkg::t_status status_q[$];

    srrc_pkg::t_addr   route_addrs[srrc_pkg::MAX_ADDRS];
    int                route_len;
    bit                repeat_mark;
    bit                overflow_mark;

    int                src_gap;
    int                sink_gap;
    int                errors;
    int unsigned       cycles;

    source_route_repeat_check dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_addr    (i_addr),
        .i_is_last (i_is_last),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit calm_phase();
        return pending_beats.size() < CALM_TAIL;
    endfunction

    // Compare against stored hops, store non-last, emit status on last.
    task automatic track_address(input srrc_pkg::t_addr a, input logic last);
        bit hit = 1'b0;
        for (int k = 0; k < route_len; k++)
            if (route_addrs[k] == a) hit = 1'b1;
        if (hit) repeat_mark = 1'b1;
        if (!last) begin
            if (route_len < srrc_pkg::MAX_ADDRS) begin
                route_addrs[route_len] = a;
                route_len++;
            end else begin
                overflow_mark = 1'b1;
            end
        end else begin
            if (overflow_mark)
                status_q.push_back(srrc_pkg::ST_OVERFLOW);
            else if (repeat_mark)
                status_q.push_back(srrc_pkg::ST_REPEAT);
            else
                status_q.push_back(srrc_pkg::ST_CLEAN);
            route_len     = 0;
            repeat_mark   = 1'b0;
            overflow_mark = 1'b0;
        end
    endtask

    task automatic push_beat(input srrc_pkg::t_addr a, input logic last);
        t_route_beat b;
        b.addr = a;
        b.last = last;
        pending_beats.push_back(b);
    endtask

    always @(posedge i_clk) begin
        t_route_beat nb;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            src_gap       <= 0;
            route_len     = 0;
            repeat_mark   = 1'b0;
            overflow_mark = 1'b0;
        end else begin
            if (i_valid && !o_stall) track_address(i_addr, i_is_last);
            if (i_valid && o_stall) begin
                // hold the stalled beat
            end else if (src_gap > 0) begin
                i_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_beats.size() == 0) begin
                i_valid <= 1'b0;
            end else if (!calm_phase() && $urandom_range(7, 0) == 0) begin
                i_valid <= 1'b0;
                src_gap <= $urandom_range(15, 0);
            end else begin
                nb = pending_beats.pop_front();
                i_valid   <= 1'b1;
                i_addr    <= nb.addr;
                i_is_last <= nb.last;
            end
        end
    end

    always @(posedge i_clk) begin
        srrc_pkg::t_status want;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected status beat, expected none, actual %0d",
                             $time, o_status);
                    errors++;
                end else begin
                    want = status_q.pop_front();
                    if (o_status !== want) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want, o_status);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                i_stall  <= 1'b1;
                sink_gap <= sink_gap - 1;
            end else if (!calm_phase() && $urandom_range(9, 0) == 0) begin
                i_stall  <= 1'b1;
                sink_gap <= $urandom_range(15, 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int              hops;
        bit              narrow;
        srrc_pkg::t_addr a;

        // single-address route, all ones
        push_beat(32'hFFFF_FFFF, 1'b1);
        // clean route across the address extremes
        push_beat(32'h0000_0000, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h1234_5678, 1'b1);
        // destination repeats the source
        push_beat(32'hC0A8_0001, 1'b0);
        push_beat(32'hC0A8_0002, 1'b0);
        push_beat(32'hC0A8_0001, 1'b1);
        // fill the store, then a repeat while full: overflow wins
        for (int k = 0; k < srrc_pkg::MAX_ADDRS; k++) push_beat(32'h0A00_0000 + k, 1'b0);
        push_beat(32'h0A00_0003, 1'b0);
        push_beat(32'h0A00_0020, 1'b1);

        while (pending_beats.size() < 1425) begin
            hops   = ($urandom_range(9, 0) < 7) ? $urandom_range(15, 0)
                                                : $urandom_range(20, 14);
            narrow = ($urandom_range(2, 0) == 0);
            for (int h = 0; h <= hops; h++) begin
                a = narrow ? (32'hC0A8_0000 | $urandom_range(5, 0))
                           : srrc_pkg::t_addr'($urandom());
                push_beat(a, h == hops);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_valid || status_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
